// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define HRPC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrpc implication check failed");

// Delayed implication: ante implies cons after the delay given by dly.
`define HRPC_ASSERT_DELAY(lbl, clk, rst, ante, dly, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("hrpc delayed check failed");

`endif

// ===== src/hrpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hrpc_pkg;

   localparam int unsigned DATA_W = 20;   // dxx, dyy, dxy
   localparam int unsigned CSR_W  = 19;   // widest register
   localparam int unsigned LIM_W  = 19;   // eigenvalue limits
   localparam int unsigned DIR_W  = 16;   // direction bounds
   localparam int unsigned N_W    = 41;   // (l1-l2)^2
   localparam int unsigned QSQ_W  = 40;   // (a-c)^2
   localparam int unsigned H2_W   = 63;   // (dir^2 - 2^31)^2

   localparam logic [LIM_W-1:0] SMALL_LIMIT_RESET    = 19'd80;
   localparam logic [LIM_W-1:0] LARGE_LIMIT_RESET    = 19'd96;
   localparam logic [DIR_W-1:0] VERTICAL_MAX_RESET   = 16'd26214;
   localparam logic [DIR_W-1:0] HORIZONTAL_MIN_RESET = 16'd32768;

   // 0.5 in Q0.32, the split point of v^2 against the squared bound
   localparam logic [31:0] HALF_Q32 = 32'h8000_0000;

   typedef enum logic [1:0] {
      REG_SMALL_LIMIT    = 2'd0,
      REG_LARGE_LIMIT    = 2'd1,
      REG_VERTICAL_MAX   = 2'd2,
      REG_HORIZONTAL_MIN = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      CLASS_NONE  = 2'd0,
      CLASS_STEEP = 2'd1,
      CLASS_FLAT  = 2'd2
   } dir_class_type;

   // Derived constants of one direction bound
   typedef struct packed {
      logic [H2_W-1:0] h2;
      logic            h_pos;
      logic            h_zero;
   } dir_const_type;

   typedef struct packed {
      logic [LIM_W-1:0] small_lim;
      logic [LIM_W-1:0] large_lim;
      dir_const_type    vert;
      dir_const_type    horiz;
   } cfg_type;

   // Eigenvalue stage result
   typedef struct packed {
      logic             valid;
      logic             ridge_ok;
      logic             n_zero;
      logic             dir_pos;
      logic             q_neg;
      logic             q_zero;
      logic [N_W-1:0]   n;
      logic [QSQ_W-1:0] qsq;
   } eig_type;

   // Direction compare result: v^2 below / above the squared bound
   typedef struct packed {
      logic lt;
      logic gt;
   } dir_res_type;

endpackage

`default_nettype wire

// ===== src/hrpc_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hrpc_cfg (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [hrpc_pkg::CSR_W-1:0]  csr_wdata,
   output hrpc_pkg::cfg_type           cfg
);

   logic [hrpc_pkg::LIM_W-1:0] small_ff;
   logic [hrpc_pkg::LIM_W-1:0] large_ff;
   logic [hrpc_pkg::DIR_W-1:0] vmax_ff;
   logic [hrpc_pkg::DIR_W-1:0] hmin_ff;

   logic [31:0] vsq_ff, vsq_in;
   logic [31:0] hsq_ff, hsq_in;
   hrpc_pkg::dir_const_type vk_ff, vk_in;
   hrpc_pkg::dir_const_type hk_ff, hk_in;

   // |dsq - 2^31|
   function automatic logic [31:0] half_dist(input logic [31:0] dsq);
      logic [31:0] d;
      if (dsq >= hrpc_pkg::HALF_Q32) begin
         d = dsq - hrpc_pkg::HALF_Q32;
      end else begin
         d = hrpc_pkg::HALF_Q32 - dsq;
      end
      return d;
   endfunction

   function automatic hrpc_pkg::dir_const_type derive(input logic [31:0] dsq);
      hrpc_pkg::dir_const_type k;
      logic [31:0] hm;
      logic [63:0] full;
      hm       = half_dist(dsq);
      full     = hm * hm;
      k.h2     = full[hrpc_pkg::H2_W-1:0];
      k.h_pos  = dsq > hrpc_pkg::HALF_Q32;
      k.h_zero = dsq == hrpc_pkg::HALF_Q32;
      return k;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         small_ff <= hrpc_pkg::SMALL_LIMIT_RESET;
         large_ff <= hrpc_pkg::LARGE_LIMIT_RESET;
         vmax_ff  <= hrpc_pkg::VERTICAL_MAX_RESET;
         hmin_ff  <= hrpc_pkg::HORIZONTAL_MIN_RESET;
      end else if (csr_we) begin
         case (hrpc_pkg::reg_index_type'(csr_index))
            hrpc_pkg::REG_SMALL_LIMIT:    small_ff <= csr_wdata[hrpc_pkg::LIM_W-1:0];
            hrpc_pkg::REG_LARGE_LIMIT:    large_ff <= csr_wdata[hrpc_pkg::LIM_W-1:0];
            hrpc_pkg::REG_VERTICAL_MAX:   vmax_ff  <= csr_wdata[hrpc_pkg::DIR_W-1:0];
            hrpc_pkg::REG_HORIZONTAL_MIN: hmin_ff  <= csr_wdata[hrpc_pkg::DIR_W-1:0];
            default: ;
         endcase
      end
   end

   // Square the bounds, then square their distance from one half
   assign vsq_in = vmax_ff * vmax_ff;
   assign hsq_in = hmin_ff * hmin_ff;
   assign vk_in  = derive(vsq_ff);
   assign hk_in  = derive(hsq_ff);

   always_ff @(posedge clock) begin
      vsq_ff <= vsq_in;
      hsq_ff <= hsq_in;
      vk_ff  <= vk_in;
      hk_ff  <= hk_in;
   end

   assign cfg.small_lim = small_ff;
   assign cfg.large_lim = large_ff;
   assign cfg.vert      = vk_ff;
   assign cfg.horiz     = hk_ff;

endmodule

`default_nettype wire

// ===== src/hrpc_eig.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hrpc_eig (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [hrpc_pkg::DATA_W-1:0]  dxx,
   input  logic signed [hrpc_pkg::DATA_W-1:0]  dyy,
   input  logic signed [hrpc_pkg::DATA_W-1:0]  dxy,
   input  hrpc_pkg::cfg_type                   cfg,
   output hrpc_pkg::eig_type                   eig
);

   localparam int unsigned DW  = hrpc_pkg::DATA_W;
   localparam int unsigned PW  = DW + 1;       // a+c, a-c
   localparam int unsigned TW  = DW + 2;       // root bounds
   localparam int unsigned SQW = 2 * TW - 1;   // squared root bounds
   localparam int unsigned NW  = hrpc_pkg::N_W;
   localparam int unsigned QW  = hrpc_pkg::QSQ_W;

   function automatic logic [SQW-1:0] sq_bound(input logic signed [TW-1:0] x);
      logic signed [2*TW-1:0] f;
      f = x * x;
      return f[SQW-1:0];
   endfunction

   // stage 1: input capture
   logic                 v1_ff;
   logic signed [DW-1:0] a1_ff, c1_ff, b1_ff;

   // stage 2: sum, difference, |b|
   logic                 v2_ff;
   logic signed [PW-1:0] p2_ff, p2_in;
   logic signed [PW-1:0] q2_ff, q2_in;
   logic [DW-1:0]        bm2_ff, bm2_in;
   logic                 bnz2_ff;

   // stage 3: root bounds, |q|
   logic                 v3_ff;
   logic signed [TW-1:0] t3_ff [4];
   logic signed [TW-1:0] t3_in [4];
   logic [DW-1:0]        qm3_ff, qm3_in;
   logic [DW-1:0]        bm3_ff;
   logic                 qneg3_ff, qzero3_ff, pos3_ff;
   logic                 qzero3_in, pos3_in;
   logic [DW-1:0]        s2;
   logic [DW-1:0]        l2x;

   // stage 4: squares
   logic                 v4_ff;
   logic [SQW-1:0]       sq4_ff [4];
   logic                 fl4_ff [4];
   logic [QW-1:0]        qsq4_ff, qsq4_in;
   logic [NW-1:0]        rsq4_ff;
   logic [2*PW-1:0]      rsq4_full;
   logic                 qneg4_ff, qzero4_ff, pos4_ff;

   // stage 5: n
   logic                 v5_ff;
   logic [NW-1:0]        n5_ff, n5_in;
   logic [SQW-1:0]       sq5_ff [4];
   logic                 fl5_ff [4];
   logic [QW-1:0]        qsq5_ff;
   logic                 qneg5_ff, qzero5_ff, pos5_ff;

   // stage 6: ridge test
   hrpc_pkg::eig_type    e6_ff, e6_in;
   logic [SQW-1:0]       nx;
   logic                 small_ok, large_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // stage 2
   assign p2_in  = PW'(a1_ff) + PW'(c1_ff);
   assign q2_in  = PW'(a1_ff) - PW'(c1_ff);
   assign bm2_in = b1_ff[DW-1] ? DW'(-b1_ff) : DW'(b1_ff);

   // stage 3: bounds of the four root compares
   assign s2  = {cfg.small_lim, 1'b0};
   assign l2x = {cfg.large_lim, 1'b0};

   always_comb begin
      t3_in[0] =  $signed({2'b00, s2}) - TW'(p2_ff);
      t3_in[1] = -$signed({2'b00, s2}) - TW'(p2_ff);
      t3_in[2] =  TW'(p2_ff) - $signed({2'b00, l2x});
      t3_in[3] =  TW'(p2_ff) + $signed({2'b00, l2x});
   end

   assign qm3_in    = q2_ff[PW-1] ? DW'(-q2_ff) : DW'(q2_ff);
   assign qzero3_in = (q2_ff == '0);
   assign pos3_in   = bnz2_ff || (!q2_ff[PW-1] && !qzero3_in);

   // stage 4
   assign qsq4_in   = qm3_ff * qm3_ff;
   assign rsq4_full = {1'b0, bm3_ff, 1'b0} * {1'b0, bm3_ff, 1'b0};

   // stage 5
   assign n5_in = NW'(qsq4_ff) + rsq4_ff;

   // stage 6: sqrt(n) against each bound, done squared
   assign nx       = SQW'(n5_ff);
   assign small_ok = (fl5_ff[0] && (nx < sq5_ff[0])) && (fl5_ff[1] || (nx > sq5_ff[1]));
   assign large_ok = (fl5_ff[2] && (nx < sq5_ff[2])) || (fl5_ff[3] || (nx > sq5_ff[3]));

   always_comb begin
      e6_in.valid    = v5_ff;
      e6_in.ridge_ok = small_ok && large_ok;
      e6_in.n_zero   = (n5_ff == '0);
      e6_in.dir_pos  = pos5_ff;
      e6_in.q_neg    = qneg5_ff;
      e6_in.q_zero   = qzero5_ff;
      e6_in.n        = n5_ff;
      e6_in.qsq      = qsq5_ff;
   end

   always_ff @(posedge clock) begin
      a1_ff     <= dxx;
      c1_ff     <= dyy;
      b1_ff     <= dxy;

      p2_ff     <= p2_in;
      q2_ff     <= q2_in;
      bm2_ff    <= bm2_in;
      bnz2_ff   <= (b1_ff != '0);

      qm3_ff    <= qm3_in;
      bm3_ff    <= bm2_ff;
      qneg3_ff  <= q2_ff[PW-1];
      qzero3_ff <= qzero3_in;
      pos3_ff   <= pos3_in;

      qsq4_ff   <= qsq4_in;
      rsq4_ff   <= rsq4_full[NW-1:0];
      qneg4_ff  <= qneg3_ff;
      qzero4_ff <= qzero3_ff;
      pos4_ff   <= pos3_ff;

      n5_ff     <= n5_in;
      qsq5_ff   <= qsq4_ff;
      qneg5_ff  <= qneg4_ff;
      qzero5_ff <= qzero4_ff;
      pos5_ff   <= pos4_ff;

      for (int i = 0; i < 4; i++) begin
         t3_ff[i]  <= t3_in[i];
         sq4_ff[i] <= sq_bound(t3_ff[i]);
         sq5_ff[i] <= sq4_ff[i];
         fl5_ff[i] <= fl4_ff[i];
      end
      // upper bounds need a positive limit, lower bounds pass when negative
      fl4_ff[0] <= !t3_ff[0][TW-1] && (t3_ff[0] != '0);
      fl4_ff[1] <=  t3_ff[1][TW-1];
      fl4_ff[2] <= !t3_ff[2][TW-1] && (t3_ff[2] != '0);
      fl4_ff[3] <=  t3_ff[3][TW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e6_ff <= '0;
      end else begin
         e6_ff <= e6_in;
      end
   end

   assign eig = e6_ff;

endmodule

`default_nettype wire

// ===== src/hrpc_dir.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hrpc_dir (
   input  logic                          clock,
   input  logic [hrpc_pkg::N_W-1:0]      n,
   input  logic [hrpc_pkg::QSQ_W-1:0]    qsq,
   input  logic                          q_neg,
   input  logic                          q_zero,
   input  hrpc_pkg::dir_const_type       k,
   output hrpc_pkg::dir_res_type         res
);

   localparam int unsigned NW  = hrpc_pkg::N_W;
   localparam int unsigned QW  = hrpc_pkg::QSQ_W;
   localparam int unsigned HW  = hrpc_pkg::H2_W;
   localparam int unsigned NLO = 21;
   localparam int unsigned NHI = NW - NLO;
   localparam int unsigned HLO = 32;
   localparam int unsigned HHI = HW - HLO;
   localparam int unsigned AW  = NW + HHI;        // n * h2 upper half
   localparam int unsigned BW  = NW + HLO;        // n * h2 lower half
   localparam int unsigned PRW = NW + HW;         // full product
   localparam int unsigned LSH = 62;              // q^2 scaled by 2^62

   // signs of both sides of the compare
   logic signed [1:0] sl, sr;
   logic              diff_in, fixgt_in;

   // stage D1: partial products
   logic [NLO+HLO-1:0] pp_ll_ff;
   logic [NLO+HHI-1:0] pp_lh_ff;
   logic [NHI+HLO-1:0] pp_hl_ff;
   logic [NHI+HHI-1:0] pp_hh_ff;
   logic [QW-1:0]      qsq1_ff;
   logic               diff1_ff, fixgt1_ff, zero1_ff, flip1_ff;

   // stage D2: half sums
   logic [AW-1:0]      nh_hi_ff, nh_hi_in;
   logic [BW-1:0]      nh_lo_ff, nh_lo_in;
   logic [QW-1:0]      qsq2_ff;
   logic               diff2_ff, fixgt2_ff, zero2_ff, flip2_ff;

   // stage D3: full product
   logic [PRW-1:0]     prod3_ff, prod3_in;
   logic [PRW-1:0]     lhs3_ff, lhs3_in;
   logic               diff3_ff, fixgt3_ff, zero3_ff, flip3_ff;

   // stage D4: verdict
   hrpc_pkg::dir_res_type res_ff, res_in;
   logic               c_gt, c_lt;

   always_comb begin
      sl       = q_neg ? -2'sd1 : (q_zero ? 2'sd0 : 2'sd1);
      sr       = k.h_pos ? 2'sd1 : (k.h_zero ? 2'sd0 : -2'sd1);
      diff_in  = (sl != sr);
      fixgt_in = (sl > sr);
   end

   assign nh_hi_in = {pp_hh_ff, {NLO{1'b0}}} + AW'(pp_lh_ff);
   assign nh_lo_in = {pp_hl_ff, {NLO{1'b0}}} + BW'(pp_ll_ff);
   assign prod3_in = {nh_hi_ff, {HLO{1'b0}}} + PRW'(nh_lo_ff);
   assign lhs3_in  = PRW'({qsq2_ff, {LSH{1'b0}}});

   assign c_gt = lhs3_ff > prod3_ff;
   assign c_lt = lhs3_ff < prod3_ff;

   always_comb begin
      if (diff3_ff) begin
         res_in.gt = fixgt3_ff;
         res_in.lt = !fixgt3_ff;
      end else if (zero3_ff) begin
         res_in.gt = 1'b0;
         res_in.lt = 1'b0;
      end else if (flip3_ff) begin
         res_in.gt = c_lt;
         res_in.lt = c_gt;
      end else begin
         res_in.gt = c_gt;
         res_in.lt = c_lt;
      end
   end

   always_ff @(posedge clock) begin
      pp_ll_ff  <= n[NLO-1:0]  * k.h2[HLO-1:0];
      pp_lh_ff  <= n[NLO-1:0]  * k.h2[HW-1:HLO];
      pp_hl_ff  <= n[NW-1:NLO] * k.h2[HLO-1:0];
      pp_hh_ff  <= n[NW-1:NLO] * k.h2[HW-1:HLO];
      qsq1_ff   <= qsq;
      diff1_ff  <= diff_in;
      fixgt1_ff <= fixgt_in;
      zero1_ff  <= (sl == 2'sd0);
      flip1_ff  <= q_neg;

      nh_hi_ff  <= nh_hi_in;
      nh_lo_ff  <= nh_lo_in;
      qsq2_ff   <= qsq1_ff;
      diff2_ff  <= diff1_ff;
      fixgt2_ff <= fixgt1_ff;
      zero2_ff  <= zero1_ff;
      flip2_ff  <= flip1_ff;

      prod3_ff  <= prod3_in;
      lhs3_ff   <= lhs3_in;
      diff3_ff  <= diff2_ff;
      fixgt3_ff <= fixgt2_ff;
      zero3_ff  <= zero2_ff;
      flip3_ff  <= flip2_ff;

      res_ff    <= res_in;
   end

   assign res = res_ff;

endmodule

`default_nettype wire

// ===== src/hessian_ridge_pixel_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Result path: an item accepted at a rising edge reaches the rsp_ ports through ten eigenvalue
//   and direction stages plus the output register.
// Throughput: one item per cycle; busy is low whenever reset is low, and the result strobe
//   cannot be held off, so the eleven-stage pipeline never stalls.
// Reset: synchronous, active high; drops every item in flight, restores the four limit
//   registers to their defaults and holds busy high while asserted.
module hessian_ridge_pixel_classifier (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                start,
   output logic                                busy,
   input  logic signed [hrpc_pkg::DATA_W-1:0]  req_dxx,
   input  logic signed [hrpc_pkg::DATA_W-1:0]  req_dyy,
   input  logic signed [hrpc_pkg::DATA_W-1:0]  req_dxy,

   output logic                                rsp_valid,
   output logic                                rsp_ridge_mark,
   output logic [1:0]                          rsp_direction_class,

   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [hrpc_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int unsigned DIR_STAGES = 4;

   // Facts of the ridge test that wait for the direction compares
   typedef struct packed {
      logic valid;
      logic ridge_ok;
      logic n_zero;
      logic dir_pos;
   } side_type;

   hrpc_pkg::cfg_type     cfg;
   hrpc_pkg::eig_type     eig;
   hrpc_pkg::dir_res_type vert_res;
   hrpc_pkg::dir_res_type horiz_res;

   logic     accept;
   side_type side_ff [DIR_STAGES];
   side_type side_in;

   logic                    valid_ff;
   hrpc_pkg::dir_class_type dclass_ff, dclass_in;

   // Hold off items while reset is high; otherwise take one every cycle.
   assign busy   = reset;
   assign accept = start && !busy;

   // Limit registers and the per-bound constants derived from them
   hrpc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Six stages: input capture, sum and difference, root bounds, squares, (l1-l2)^2, ridge test
   hrpc_eig u_eig (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .dxx      (req_dxx),
      .dyy      (req_dyy),
      .dxy      (req_dxy),
      .cfg      (cfg),
      .eig      (eig)
   );

   // Eigenvector component against each bound, four stages each. The compare is
   // q^2 * 2^62 against n * (dir^2 - 2^31)^2, carried out in split partial products.
   hrpc_dir u_dir_vert (
      .clock  (clock),
      .n      (eig.n),
      .qsq    (eig.qsq),
      .q_neg  (eig.q_neg),
      .q_zero (eig.q_zero),
      .k      (cfg.vert),
      .res    (vert_res)
   );

   hrpc_dir u_dir_horiz (
      .clock  (clock),
      .n      (eig.n),
      .qsq    (eig.qsq),
      .q_neg  (eig.q_neg),
      .q_zero (eig.q_zero),
      .k      (cfg.horiz),
      .res    (horiz_res)
   );

   // Delay the ridge flags alongside the direction compares.
   always_comb begin
      side_in.valid    = eig.valid;
      side_in.ridge_ok = eig.ridge_ok;
      side_in.n_zero   = eig.n_zero;
      side_in.dir_pos  = eig.dir_pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIR_STAGES; i++) begin
            side_ff[i] <= '0;
         end
      end else begin
         side_ff[0] <= side_in;
         for (int i = 1; i < DIR_STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Class decision. Equal eigenvalues or a degenerate eigenvector count as
   // flat; steep wins when both bounds pass.
   always_comb begin
      dclass_in = hrpc_pkg::CLASS_NONE;
      if (side_ff[DIR_STAGES-1].ridge_ok) begin
         if (side_ff[DIR_STAGES-1].n_zero) begin
            dclass_in = hrpc_pkg::CLASS_FLAT;
         end else if (side_ff[DIR_STAGES-1].dir_pos && vert_res.lt) begin
            dclass_in = hrpc_pkg::CLASS_STEEP;
         end else if (horiz_res.gt) begin
            dclass_in = hrpc_pkg::CLASS_FLAT;
         end
      end
   end

   // Output register: one strobe cycle per item.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= side_ff[DIR_STAGES-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      dclass_ff <= dclass_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_direction_class = dclass_ff;
   assign rsp_ridge_mark      = (dclass_ff != hrpc_pkg::CLASS_NONE);

endmodule

`default_nettype wire

// ===== src/hrpc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hrpc_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic                                rsp_valid,
   input  logic                                rsp_ridge_mark,
   input  logic [1:0]                          rsp_direction_class
);

   localparam int unsigned RSP_LATENCY = 11;

   logic item_taken;
   logic mark_ok;

   assign item_taken = start && !busy;
   assign mark_ok    = rsp_ridge_mark ==
                       (rsp_direction_class != hrpc_pkg::CLASS_NONE);

   // every accepted item is followed by a result strobe
   `HRPC_ASSERT_DELAY(a_item_result, clock, reset, item_taken, RSP_LATENCY, rsp_valid)
   // no strobe without an item behind it
   `HRPC_ASSERT_IMPLY(a_result_origin, clock, reset, rsp_valid, $past(item_taken, RSP_LATENCY))
   // mark agrees with the class
   `HRPC_ASSERT_IMPLY(a_mark_class, clock, reset, rsp_valid, mark_ok)
   // reset drops everything in flight: no strobe just after reset is released
   `HRPC_ASSERT_IMPLY(a_reset_flush, clock, 1'b0, $past(reset) && !reset, !rsp_valid)

endmodule

bind hessian_ridge_pixel_classifier hrpc_checker u_hrpc_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_ridge_mark      (rsp_ridge_mark),
   .rsp_direction_class (rsp_direction_class)
);

`default_nettype wire
